// ----- rtl/core/hmd5_pkg.sv -----
// Shared types, constants and round tables for the HMAC-MD5 stream block.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package hmd5_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_MSG = 2'd1,
    OP_FIN = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_item_t;

  // Classified command passed from front to engine
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [31:0] MD5_IV [4] = '{32'h67452301, 32'hefcdab89,
                                        32'h98badcfe, 32'h10325476};

  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotation amount of a round
  function automatic logic [4:0] md5_s(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index of a round
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'(i * 4'd5 + 4'd1);
      2'd2:    g = 4'(i * 4'd3 + 4'd5);
      default: g = 4'(i * 4'd7);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hmd5_front.sv -----
// Input stage: accepts items, drops unknown operation codes, registers commands.
// Depends on hmd5_pkg.
`default_nettype none

module hmd5_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hmd5_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output hmd5_pkg::cmd_t         cmd_o
);

  logic           vld_q;
  hmd5_pkg::cmd_t cmd_q;
  logic           known;

  // Classify the operation code
  always_comb begin
    unique case (hmd5_pkg::op_e'(in_item_i.operation))
      hmd5_pkg::OP_KEY, hmd5_pkg::OP_MSG, hmd5_pkg::OP_FIN: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  // Hold a command until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i && known;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i && known) begin
      cmd_q.op   <= hmd5_pkg::op_e'(in_item_i.operation);
      cmd_q.data <= in_item_i.data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmd5_fifo.sv -----
// Short command queue between the front stage and the engine.
// Depends on hmd5_pkg.
`default_nettype none

module hmd5_fifo #(
  parameter int unsigned Depth = hmd5_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire hmd5_pkg::cmd_t wr_cmd_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output hmd5_pkg::cmd_t      rd_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hmd5_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmd5_engine.sv -----
// HMAC-MD5 engine: key store, block buffer, padding sequencer and a
// one-round-per-cycle MD5 compression loop. Depends on hmd5_pkg.
`default_nettype none

module hmd5_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire hmd5_pkg::cmd_t cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hmd5_pkg::out_item_t out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_ABSORB, S_BEGIN, S_START_IN, S_PAD0, S_PADZ,
    S_CINIT, S_COMP, S_CADD, S_RET, S_INNER_ABS, S_OUT
  } state_e;

  typedef enum logic [2:0] {R_IDLE, R_ABSORB, R_PHASE1, R_PADNEXT, R_OUTER} ret_e;
  typedef enum logic [1:0] {D_KEY, D_INNER, D_MAC} dig_e;
  typedef enum logic [1:0] {SRC_BUF, SRC_KEY, SRC_KEY_IN, SRC_KEY_OUT} src_e;

  localparam logic [1:0] PH_KEY = 2'd0;
  localparam logic [1:0] PH_MSG = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  state_e         state_q;
  ret_e           ret_q;
  dig_e           dig_q;
  src_e           src_q;
  hmd5_pkg::op_e  op_q;
  logic [7:0]     byte_q;
  logic [1:0]     phase_q;
  logic [6:0]     key_cnt_q;
  logic           key_long_q;
  logic [31:0]    key_q   [16];
  logic [31:0]    buf_q   [16];
  logic [31:0]    chain_q [4];
  logic [31:0]    inner_q [4];
  logic [63:0]    bit_q;
  logic [5:0]     fill_q;
  logic           pad_len_q;
  logic [5:0]     rnd_q;
  logic [31:0]    a_q, b_q, c_q, d_q;
  logic           out_valid_q;
  hmd5_pkg::out_item_t out_q;

  logic        buf_we;
  logic [7:0]  buf_byte;
  logic [3:0]  g_idx;
  logic [31:0] w_word, f_val, t_val, rot_val;
  logic [4:0]  s_val;
  logic [127:0] mac;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Select the byte written into the block buffer
  always_comb begin
    buf_we   = 1'b0;
    buf_byte = 8'h00;
    case (state_q)
      S_ABSORB: begin
        buf_we   = 1'b1;
        buf_byte = byte_q;
      end
      S_PAD0: begin
        buf_we   = 1'b1;
        buf_byte = hmd5_pkg::PAD_MARK;
      end
      S_PADZ: begin
        buf_we   = 1'b1;
        buf_byte = (pad_len_q && fill_q >= 6'd56) ? bit_q[8*fill_q[2:0] +: 8] : 8'h00;
      end
      S_INNER_ABS: begin
        buf_we   = 1'b1;
        buf_byte = inner_q[fill_q[3:2]][8*fill_q[1:0] +: 8];
      end
      default: ;
    endcase
  end

  // One MD5 round
  always_comb begin
    g_idx = hmd5_pkg::md5_g(rnd_q);
    s_val = hmd5_pkg::md5_s(rnd_q);
    case (src_q)
      SRC_BUF:     w_word = buf_q[g_idx];
      SRC_KEY:     w_word = key_q[g_idx];
      SRC_KEY_IN:  w_word = key_q[g_idx] ^ {4{hmd5_pkg::IPAD_BYTE}};
      default:     w_word = key_q[g_idx] ^ {4{hmd5_pkg::OPAD_BYTE}};
    endcase
    case (rnd_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    t_val   = a_q + f_val + hmd5_pkg::md5_k(rnd_q) + w_word;
    rot_val = (t_val << s_val) | (t_val >> (6'd32 - {1'b0, s_val}));
  end

  // Digest bytes in output order, byte 0 on top
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mac[127 - 8*i -: 8] = chain_q[i/4][8*(i%4) +: 8];
    end
  end

  // Write the block buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= buf_byte;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= R_IDLE;
      dig_q       <= D_INNER;
      src_q       <= SRC_BUF;
      op_q        <= hmd5_pkg::OP_KEY;
      byte_q      <= 8'h00;
      phase_q     <= PH_KEY;
      key_cnt_q   <= '0;
      key_long_q  <= 1'b0;
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
      for (int i = 0; i < 4; i++) chain_q[i] <= hmd5_pkg::MD5_IV[i];
      bit_q       <= '0;
      fill_q      <= '0;
      pad_len_q   <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop a taken result unless a new one is loaded this cycle
      if (out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (buf_we) begin
        fill_q <= fill_q + 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            op_q   <= cmd_i.op;
            byte_q <= cmd_i.data;
            case (cmd_i.op)
              hmd5_pkg::OP_KEY: begin
                if (phase_q != PH_KEY) begin
                  for (int i = 0; i < 16; i++) key_q[i] <= '0;
                  for (int i = 0; i < 4; i++) chain_q[i] <= hmd5_pkg::MD5_IV[i];
                  key_cnt_q  <= '0;
                  key_long_q <= 1'b0;
                  bit_q      <= '0;
                  fill_q     <= '0;
                  phase_q    <= PH_KEY;
                end
                state_q <= S_KEY;
              end
              hmd5_pkg::OP_MSG: begin
                state_q <= (phase_q != PH_MSG) ? S_BEGIN : S_ABSORB;
              end
              default: begin
                dig_q   <= D_INNER;
                state_q <= (phase_q != PH_MSG) ? S_BEGIN : S_PAD0;
              end
            endcase
          end
        end
        S_KEY: begin
          if (key_long_q) begin
            state_q <= S_ABSORB;
          end else if (key_cnt_q < 7'd64) begin
            key_q[key_cnt_q[5:2]][8*key_cnt_q[1:0] +: 8] <= byte_q;
            key_cnt_q <= key_cnt_q + 1'b1;
            state_q   <= S_IDLE;
          end else begin
            // Long key: hash the stored 64 bytes, then keep absorbing
            key_long_q <= 1'b1;
            for (int i = 0; i < 4; i++) chain_q[i] <= hmd5_pkg::MD5_IV[i];
            bit_q   <= 64'd512;
            fill_q  <= '0;
            src_q   <= SRC_KEY;
            ret_q   <= R_ABSORB;
            state_q <= S_CINIT;
          end
        end
        S_ABSORB: begin
          bit_q <= bit_q + 64'd8;
          if (fill_q == 6'd63) begin
            src_q   <= SRC_BUF;
            ret_q   <= R_IDLE;
            state_q <= S_CINIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_BEGIN: begin
          if (key_long_q) begin
            dig_q   <= D_KEY;
            state_q <= S_PAD0;
          end else begin
            state_q <= S_START_IN;
          end
        end
        S_START_IN: begin
          for (int i = 0; i < 4; i++) chain_q[i] <= hmd5_pkg::MD5_IV[i];
          bit_q   <= 64'd512;
          fill_q  <= '0;
          src_q   <= SRC_KEY_IN;
          ret_q   <= R_PHASE1;
          state_q <= S_CINIT;
        end
        S_PAD0: begin
          pad_len_q <= (fill_q <= 6'd55);
          src_q     <= SRC_BUF;
          ret_q     <= R_PADNEXT;
          state_q   <= (fill_q == 6'd63) ? S_CINIT : S_PADZ;
        end
        S_PADZ: begin
          if (fill_q == 6'd63) begin
            src_q   <= SRC_BUF;
            ret_q   <= R_PADNEXT;
            state_q <= S_CINIT;
          end
        end
        S_CINIT: begin
          a_q     <= chain_q[0];
          b_q     <= chain_q[1];
          c_q     <= chain_q[2];
          d_q     <= chain_q[3];
          state_q <= S_COMP;
        end
        S_COMP: begin
          a_q   <= d_q;
          d_q   <= c_q;
          c_q   <= b_q;
          b_q   <= b_q + rot_val;
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            state_q <= S_CADD;
          end
        end
        S_CADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          state_q    <= S_RET;
        end
        S_RET: begin
          case (ret_q)
            R_ABSORB: state_q <= S_ABSORB;
            R_PHASE1: begin
              phase_q <= PH_MSG;
              dig_q   <= D_INNER;
              state_q <= (op_q == hmd5_pkg::OP_MSG) ? S_ABSORB : S_PAD0;
            end
            R_PADNEXT: begin
              if (!pad_len_q) begin
                pad_len_q <= 1'b1;
                state_q   <= S_PADZ;
              end else begin
                case (dig_q)
                  D_KEY: begin
                    // Replace a long key by its digest
                    for (int i = 0; i < 16; i++) begin
                      key_q[i] <= (i < 4) ? chain_q[i%4] : '0;
                    end
                    key_cnt_q  <= 7'd16;
                    key_long_q <= 1'b0;
                    state_q    <= S_START_IN;
                  end
                  D_INNER: begin
                    for (int i = 0; i < 4; i++) begin
                      inner_q[i] <= chain_q[i];
                      chain_q[i] <= hmd5_pkg::MD5_IV[i];
                    end
                    bit_q   <= 64'd512;
                    fill_q  <= '0;
                    src_q   <= SRC_KEY_OUT;
                    ret_q   <= R_OUTER;
                    state_q <= S_CINIT;
                  end
                  default: state_q <= S_OUT;
                endcase
              end
            end
            R_OUTER: state_q <= S_INNER_ABS;
            default: state_q <= S_IDLE;
          endcase
        end
        S_INNER_ABS: begin
          bit_q <= bit_q + 64'd8;
          if (fill_q == 6'd15) begin
            dig_q   <= D_MAC;
            state_q <= S_PAD0;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_q.mac_high <= mac[127:64];
            out_q.mac_low  <= mac[63:0];
            phase_q        <= PH_FIN;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COMP) |-> (rnd_q == 6'd0)) else $error("round counter left running");
  a_key_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= 7'd64) else $error("key count beyond block size");
  a_inner_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INNER_ABS) |-> (fill_q < 6'd16)) else $error("inner digest overrun");
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY) || (phase_q == PH_MSG) || (phase_q == PH_FIN))
    else $error("bad phase");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT)) else $error("stray result");

endmodule

`default_nettype wire

// ----- rtl/core/hmac_md5_stream.sv -----
// Top level of the HMAC-MD5 stream block: front stage, command queue, engine.
// Depends on hmd5_pkg, hmd5_front, hmd5_fifo and hmd5_engine.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid_i/in_ready_o  | in_item_i  (operation, data_byte)
//   output  | out       | out_valid_o/out_ready_i| out_item_o (mac_high, mac_low)
//
// Key byte: stored directly, or absorbed as message data once the key is being
// hashed; the 65th key byte adds a compression (one MD5 round per cycle).
// Message byte: each 64th byte adds a compression; the first byte of a message
// adds the inner-prefix block.
// Finish: three to six compressions plus one buffer write per padding byte.
// Reset clears all control state and loads the empty key; no clearing pass.
// A stalled output holds the result while the queue keeps taking items until it is full.
`default_nettype none

module hmac_md5_stream #(
  parameter int unsigned QueueDepth = hmd5_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire hmd5_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hmd5_pkg::out_item_t      out_item_o
);

  logic           f_valid, f_ready, q_valid, q_ready;
  hmd5_pkg::cmd_t f_cmd, q_cmd;

  hmd5_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  hmd5_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_cmd_o   (q_cmd)
  );

  hmd5_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
